FILE: rtl/sre_pkg.sv
// shared types and constants for the stepper rate frame encoder
package sre_pkg;

    localparam int JOINTS      = 6;
    localparam int GEAR_REGS   = 6;
    localparam int JOINT_LIMIT = (JOINTS < GEAR_REGS) ? JOINTS : GEAR_REGS;
    localparam int JOINT_W     = (JOINT_LIMIT > 1) ? $clog2(JOINT_LIMIT) : 1;

    localparam int RATE_W   = 32;
    localparam int GEAR_W   = 16;
    localparam int INVERT_W = 6;
    localparam int MAG_W    = 24;
    localparam int DEN_W    = MAG_W + GEAR_W;
    localparam int DIV_W    = RATE_W + 8;

    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_RATE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GEAR_BASE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GEAR_LAST = 3'd7;

    localparam logic [RATE_W-1:0]   RATE_RESET   = 32'd2882423829;
    localparam logic [INVERT_W-1:0] INVERT_RESET = 6'd3;
    localparam logic [GEAR_W-1:0]   GEAR_RESET   = 16'd256;

    localparam logic [7:0]  FRAME_HEAD = 8'h66;
    localparam logic [15:0] PERIOD_MAX = 16'hFFFF;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    typedef struct packed {
        logic [2:0]         joint_index;
        logic signed [19:0] angle;
        logic signed [23:0] speed;
    } t_cmd;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_frame;

    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic             dir;
    } t_job;

endpackage

FILE: rtl/sre_front.sv
// front end: joint check, direction tracking and divisor product
module sre_front (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_push,
    input  sre_pkg::t_cmd                                i_cmd,
    input  logic                                         i_queue_full,
    input  logic [sre_pkg::INVERT_W-1:0]                 i_invert_mask,
    input  logic [sre_pkg::GEAR_REGS-1:0][sre_pkg::GEAR_W-1:0] i_gear,
    output logic                                         o_full,
    output logic                                         o_job_push,
    output sre_pkg::t_job                                o_job
);

    logic signed [19:0]              r_prev_angle [sre_pkg::JOINT_LIMIT];
    logic [sre_pkg::JOINT_LIMIT-1:0] r_held;
    logic [sre_pkg::JOINT_LIMIT-1:0] r_seen;

    logic                            accept;
    logic                            joint_ok;
    logic [sre_pkg::JOINT_W-1:0]     jidx;
    logic [sre_pkg::MAG_W-1:0]       mag;
    logic                            n_held;

    assign o_full   = i_queue_full;
    assign accept   = i_push && !i_queue_full;
    assign joint_ok = ({1'b0, i_cmd.joint_index} < 4'(sre_pkg::JOINT_LIMIT));
    assign jidx     = i_cmd.joint_index[sre_pkg::JOINT_W-1:0];

    always_comb begin
        mag = i_cmd.speed[23] ? sre_pkg::MAG_W'(-i_cmd.speed) : sre_pkg::MAG_W'(i_cmd.speed);
        n_held = r_held[jidx];
        if (r_seen[jidx]) begin
            if (i_cmd.angle > r_prev_angle[jidx]) begin
                n_held = 1'b1;
            end else if (i_cmd.angle < r_prev_angle[jidx]) begin
                n_held = 1'b0;
            end
        end
        o_job.den  = sre_pkg::DEN_W'(mag) * sre_pkg::DEN_W'(i_gear[jidx]);
        o_job.dir  = n_held ^ i_invert_mask[jidx];
        o_job_push = accept && joint_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_seen <= '0;
            for (int k = 0; k < sre_pkg::JOINT_LIMIT; k++) begin
                r_prev_angle[k] <= '0;
            end
        end else if (accept && joint_ok) begin
            r_held[jidx]       <= n_held;
            r_seen[jidx]       <= 1'b1;
            r_prev_angle[jidx] <= i_cmd.angle;
        end
    end

endmodule

FILE: rtl/sre_queue.sv
// short job queue between front and back
module sre_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sre_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output sre_pkg::t_job o_job
);

    localparam int PTR_W = (sre_pkg::QUEUE_DEPTH > 1) ? $clog2(sre_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(sre_pkg::QUEUE_DEPTH + 1);

    sre_pkg::t_job    r_mem [sre_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(sre_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(sre_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(sre_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/sre_back.sv
// back end: iterative period divide, crc and byte output register
module sre_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [sre_pkg::RATE_W-1:0]  i_rate,
    input  logic                        i_queue_empty,
    input  sre_pkg::t_job               i_job,
    output logic                        o_queue_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output sre_pkg::t_frame             o_frame
);

    localparam int DW    = sre_pkg::DIV_W;
    localparam int CNT_W = $clog2(DW);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ sre_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    t_state                  r_state;
    logic [CNT_W-1:0]        r_cnt;
    logic [2:0]              r_idx;
    logic [sre_pkg::DEN_W-1:0] r_den;
    logic                    r_dir;
    logic [DW-1:0]           r_rem;
    logic [DW-1:0]           r_quo;
    logic [15:0]             r_crc;
    logic                    r_out_valid;
    sre_pkg::t_frame         r_out;

    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          ge;
    logic [15:0]   period;
    logic [7:0]    byte_sel;
    logic          load;

    assign o_queue_pop = (r_state == S_IDLE) && !i_queue_empty;
    assign o_empty     = !r_out_valid;
    assign o_frame     = r_out;
    assign load        = (r_state == S_EMIT) && (!r_out_valid || i_pop);

    always_comb begin
        rem_sh = {r_rem, r_quo[DW-1]};
        diff   = rem_sh - {1'b0, DW'(r_den)};
        ge     = !diff[DW];

        if ((r_quo == '0) || (r_quo[DW-1:16] != '0)) begin
            period = sre_pkg::PERIOD_MAX;
        end else begin
            period = r_quo[15:0];
        end

        case (r_idx)
            3'd0:    byte_sel = sre_pkg::FRAME_HEAD;
            3'd1:    byte_sel = period[7:0];
            3'd2:    byte_sel = period[15:8];
            3'd3:    byte_sel = {7'd0, r_dir};
            3'd4:    byte_sel = r_crc[7:0];
            default: byte_sel = r_crc[15:8];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid && !load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_queue_empty) begin
                        r_den   <= i_job.den;
                        r_dir   <= i_job.dir;
                        r_rem   <= '0;
                        r_quo   <= {i_rate, 8'h00};
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
                    r_quo <= {r_quo[DW-2:0], ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DW - 1)) begin
                        r_idx   <= '0;
                        r_crc   <= sre_pkg::CRC_INIT;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (load) begin
                        r_out.frame_byte <= byte_sel;
                        r_out.last_byte  <= (r_idx == 3'd5);
                        r_out_valid      <= 1'b1;
                        if (r_idx < 3'd4) begin
                            r_crc <= crc_byte(r_crc, byte_sel);
                        end
                        if (r_idx == 3'd5) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/stepper_rate_frame_encoder.sv
// top level of the stepper rate frame encoder: configuration registers and wiring
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------
//   command  | push / full        | i_cmd   (joint_index, angle, speed)
//   frame    | pop / empty        | o_frame (frame_byte, last_byte)
//   config   | i_cfg_we           | i_cfg_index, i_cfg_data
//
// the front end is combinational and passes each accepted command to the queue; the back end
// then performs one queue pop, 40 restoring divide steps and six byte transfers
// the 40-step divider sets the sustained rate; a two-entry queue decouples the front
// reset clears per-joint angle state and loads the config reset values
// a stalled frame output holds the back end; the front keeps taking items until the queue fills
module stepper_rate_frame_encoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  sre_pkg::t_cmd                     i_cmd,
    input  logic                              pop,
    output logic                              empty,
    output sre_pkg::t_frame                   o_frame,
    input  logic                              i_cfg_we,
    input  logic [sre_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [sre_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [sre_pkg::RATE_W-1:0]                          r_rate;
    logic [sre_pkg::INVERT_W-1:0]                        r_invert;
    logic [sre_pkg::GEAR_REGS-1:0][sre_pkg::GEAR_W-1:0]  r_gear;

    logic [sre_pkg::CFG_INDEX_W-1:0] gear_sel;
    logic                            job_push;
    sre_pkg::t_job                   job_in;
    logic                            q_full;
    logic                            q_empty;
    logic                            q_pop;
    sre_pkg::t_job                   job_out;

    assign gear_sel = i_cfg_index - sre_pkg::CFG_GEAR_BASE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= sre_pkg::RATE_RESET;
            r_invert <= sre_pkg::INVERT_RESET;
            for (int k = 0; k < sre_pkg::GEAR_REGS; k++) begin
                r_gear[k] <= sre_pkg::GEAR_RESET;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index) inside
                sre_pkg::CFG_RATE: begin
                    r_rate <= i_cfg_data[sre_pkg::RATE_W-1:0];
                end
                sre_pkg::CFG_INVERT: begin
                    r_invert <= i_cfg_data[sre_pkg::INVERT_W-1:0];
                end
                [sre_pkg::CFG_GEAR_BASE:sre_pkg::CFG_GEAR_LAST]: begin
                    r_gear[gear_sel] <= i_cfg_data[sre_pkg::GEAR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    sre_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_cmd         (i_cmd),
        .i_queue_full  (q_full),
        .i_invert_mask (r_invert),
        .i_gear        (r_gear),
        .o_full        (full),
        .o_job_push    (job_push),
        .o_job         (job_in)
    );

    sre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (job_out)
    );

    sre_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rate        (r_rate),
        .i_queue_empty (q_empty),
        .i_job         (job_out),
        .o_queue_pop   (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_frame       (o_frame)
    );

endmodule

FILE: test/stepper_rate_frame_encoder_tb.sv
// self-checking testbench for the stepper rate frame encoder: directed and random commands
module stepper_rate_frame_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    class stepper_frame_tracker;
        logic [sre_pkg::RATE_W-1:0]   rate_num;
        logic [sre_pkg::INVERT_W-1:0] dir_invert;
        logic [sre_pkg::GEAR_W-1:0]   gear [sre_pkg::GEAR_REGS];
        logic signed [19:0]           last_angle [sre_pkg::GEAR_REGS];
        logic                         heading [sre_pkg::GEAR_REGS];
        logic                         angle_valid [sre_pkg::GEAR_REGS];
        sre_pkg::t_frame              pending_bytes [$];
        int                           errors;
        int                           bytes_checked;

        function new();
            rate_num = sre_pkg::RATE_RESET;
            dir_invert = sre_pkg::INVERT_RESET;
            for (int j = 0; j < sre_pkg::GEAR_REGS; j++) begin
                gear[j] = sre_pkg::GEAR_RESET;
                last_angle[j] = '0;
                heading[j] = 1'b0;
                angle_valid[j] = 1'b0;
            end
            errors = 0;
            bytes_checked = 0;
        endfunction

        function void set_register(logic [sre_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [sre_pkg::CFG_DATA_W-1:0] data);
            if (idx == sre_pkg::CFG_RATE) begin
                rate_num = data;
            end else if (idx == sre_pkg::CFG_INVERT) begin
                dir_invert = data[sre_pkg::INVERT_W-1:0];
            end else if (idx >= sre_pkg::CFG_GEAR_BASE && idx <= sre_pkg::CFG_GEAR_LAST) begin
                gear[idx - sre_pkg::CFG_GEAR_BASE] = data[sre_pkg::GEAR_W-1:0];
            end
        endfunction

        function void take_command(sre_pkg::t_cmd c);
            logic [sre_pkg::MAG_W-1:0] mag;
            logic [sre_pkg::DEN_W-1:0] den;
            logic [sre_pkg::DIV_W-1:0] quo;
            logic [15:0]               period;
            logic [15:0]               crc;
            logic                      dir;
            logic [7:0]                frame [6];
            int                        j;
            j = c.joint_index;
            if (j >= sre_pkg::JOINT_LIMIT) return;
            mag = (c.speed < 0) ? -c.speed : c.speed;
            den = sre_pkg::DEN_W'(mag) * sre_pkg::DEN_W'(gear[j]);
            if (den == 0) begin
                period = sre_pkg::PERIOD_MAX;
            end else begin
                quo = {rate_num, 8'h00} / den;
                period = (quo == 0 || quo > sre_pkg::PERIOD_MAX) ? sre_pkg::PERIOD_MAX
                                                                 : quo[15:0];
            end
            if (angle_valid[j]) begin
                if (c.angle > last_angle[j]) begin
                    heading[j] = 1'b1;
                end else if (c.angle < last_angle[j]) begin
                    heading[j] = 1'b0;
                end
            end
            last_angle[j] = c.angle;
            angle_valid[j] = 1'b1;
            dir = heading[j] ^ dir_invert[j];
            frame[0] = sre_pkg::FRAME_HEAD;
            frame[1] = period[7:0];
            frame[2] = period[15:8];
            frame[3] = {7'd0, dir};
            crc = sre_pkg::CRC_INIT;
            for (int k = 0; k < 4; k++) begin
                crc = crc ^ {8'h00, frame[k]};
                for (int b = 0; b < 8; b++) begin
                    crc = crc[0] ? ((crc >> 1) ^ sre_pkg::CRC_POLY) : (crc >> 1);
                end
            end
            frame[4] = crc[7:0];
            frame[5] = crc[15:8];
            for (int k = 0; k < 6; k++) begin
                pending_bytes.push_back(sre_pkg::t_frame'{frame_byte: frame[k],
                                                          last_byte: (k == 5)});
            end
        endfunction

        function void check_byte(sre_pkg::t_frame got);
            sre_pkg::t_frame want;
            if (pending_bytes.size() == 0) begin
                $error("frame transfer with nothing expected: frame_byte %02h last_byte %0b",
                       got.frame_byte, got.last_byte);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            bytes_checked++;
            if (got.frame_byte !== want.frame_byte) begin
                $error("frame_byte: expected %02h, actual %02h", want.frame_byte, got.frame_byte);
                errors++;
            end
            if (got.last_byte !== want.last_byte) begin
                $error("last_byte: expected %0b, actual %0b", want.last_byte, got.last_byte);
                errors++;
            end
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            push;
    logic                            full;
    sre_pkg::t_cmd                   i_cmd;
    logic                            pop;
    logic                            empty;
    sre_pkg::t_frame                 o_frame;
    logic                            i_cfg_we;
    logic [sre_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [sre_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    stepper_frame_tracker tracker = new();
    bit                   quiet = 1'b0;
    int                   commands_sent = 0;
    int                   ignored_sent = 0;
    int                   settings_used = 0;
    logic signed [19:0]   sent_angle [sre_pkg::GEAR_REGS] = '{default: '0};

    stepper_rate_frame_encoder uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic sre_pkg::t_cmd make_cmd(int j, int a, int s);
        sre_pkg::t_cmd c;
        c.joint_index = 3'(j);
        c.angle = 20'(a);
        c.speed = 24'(s);
        return c;
    endfunction

    function automatic sre_pkg::t_cmd random_command();
        sre_pkg::t_cmd c;
        int            j;
        int            pick;
        if ($urandom_range(0, 11) == 0) begin
            c.joint_index = 3'($urandom_range(6, 7));
        end else begin
            c.joint_index = 3'($urandom_range(0, 5));
        end
        j = c.joint_index;
        pick = $urandom_range(0, 9);
        if (j >= sre_pkg::JOINT_LIMIT) begin
            c.angle = 20'($urandom);
        end else begin
            case (pick)
                0, 1: c.angle = sent_angle[j];
                2, 3, 4, 5: c.angle = sent_angle[j] + 20'($urandom_range(0, 6)) - 20'd3;
                6: c.angle = $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
                default: c.angle = 20'($urandom);
            endcase
            sent_angle[j] = c.angle;
        end
        pick = $urandom_range(0, 9);
        case (pick)
            0: c.speed = '0;
            1: c.speed = 24'sh7FFFFF;
            2: c.speed = 24'sh800000;
            3: c.speed = $urandom_range(0, 1) ? 24'sd1 : -24'sd1;
            default: c.speed = $signed(24'($urandom)) >>> $urandom_range(0, 20);
        endcase
        return c;
    endfunction

    task automatic send_command(input sre_pkg::t_cmd c);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (full);
        tracker.take_command(c);
        if (c.joint_index < sre_pkg::JOINT_LIMIT) begin
            commands_sent++;
        end else begin
            ignored_sent++;
        end
    endtask

    task automatic settle();
        push <= 1'b0;
        while (tracker.pending_bytes.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [sre_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [sre_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.set_register(idx, data);
    endtask

    task automatic apply_settings(input logic [31:0] rate, input logic [5:0] inv,
                                  input logic [5:0][15:0] gears);
        write_register(sre_pkg::CFG_RATE, rate);
        write_register(sre_pkg::CFG_INVERT, 32'(inv));
        for (int k = 0; k < sre_pkg::GEAR_REGS; k++) begin
            write_register(sre_pkg::CFG_GEAR_BASE + 3'(k), 32'(gears[k]));
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin
        int stall;
        stall = 0;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) tracker.check_byte(o_frame);
            if (stall > 0) begin
                stall--;
                pop <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(0, 5);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        logic [31:0]      rate;
        logic [5:0]       inv;
        logic [5:0][15:0] gears;
        int               start;
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_cmd <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: first items, rise, hold, fall, saturation and ignored joints
        send_command(make_cmd(0, 0, 0));
        send_command(make_cmd(0, 524287, 8388607));
        send_command(make_cmd(0, 524287, -8388608));
        send_command(make_cmd(0, -524288, 1));
        send_command(make_cmd(1, -1, -1));
        send_command(make_cmd(1, -1, 44000));
        send_command(make_cmd(1, 0, -43980));
        send_command(make_cmd(2, 100, 300000));
        send_command(make_cmd(3, -100, -300000));
        send_command(make_cmd(4, 1, 65536));
        send_command(make_cmd(5, 2, -65536));
        send_command(make_cmd(6, 5, 5));
        send_command(make_cmd(7, 5, 5));
        send_command(make_cmd(5, 1, 8388607));
        settle();

        // zero rate gives a zero quotient, zero gear on the last joint
        gears = {16'd0, 16'd1, 16'd65535, 16'd1, 16'd65535, 16'd1};
        apply_settings(32'd0, 6'h3F, gears);
        send_command(make_cmd(0, 10, 1000));
        send_command(make_cmd(5, 0, 1000));
        send_command(make_cmd(2, -5, -8388608));
        settle();

        gears = {16'd1, 16'd65535, 16'd1, 16'd65535, 16'd1, 16'd65535};
        apply_settings(32'hFFFF_FFFF, 6'h2A, gears);
        send_command(make_cmd(0, 10, 1));
        send_command(make_cmd(1, -10, -8388608));

        for (int p = 0; p < 6; p++) begin
            settle();
            if (p == 0) begin
                rate = 32'hFFFF_FFFF;
                inv = 6'h3F;
                for (int k = 0; k < sre_pkg::GEAR_REGS; k++) gears[k] = 16'hFFFF;
            end else if (p == 1) begin
                rate = $urandom >> $urandom_range(8, 16);
                inv = 6'h00;
                for (int k = 0; k < sre_pkg::GEAR_REGS; k++) gears[k] = 16'd1;
            end else begin
                rate = $urandom;
                inv = 6'($urandom_range(0, 63));
                for (int k = 0; k < sre_pkg::GEAR_REGS; k++) begin
                    gears[k] = 16'($urandom_range(1, 65535 >> $urandom_range(0, 15)));
                end
            end
            if (p == 5) quiet = 1'b1;
            apply_settings(rate, inv, gears);
            start = commands_sent;
            while (commands_sent - start < 66) send_command(random_command());
        end
        settle();

        $display("checked %0d frame bytes from %0d commands, %0d commands to absent joints",
                 tracker.bytes_checked, commands_sent, ignored_sent);
        $display("%0d register settings applied, rate and gear extremes and zero gear among them",
                 settings_used);
        if (tracker.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: stepper_rate_frame_encoder.f
rtl/sre_pkg.sv
rtl/sre_front.sv
rtl/sre_queue.sv
rtl/sre_back.sv
rtl/stepper_rate_frame_encoder.sv
test/stepper_rate_frame_encoder_tb.sv
